// File: rtl/kscd_pkg.sv
// ----------------------------------------------------------------------------
// Keyboard scan code decoder package
// Widths, scan-code constants, register indexes and the multi-byte sequence
// table that the decoder matches against.
// ----------------------------------------------------------------------------
package kscd_pkg;

   localparam int unsigned SCAN_W     = 8;
   localparam int unsigned CODE_W     = 8;
   localparam int unsigned TICK_W     = 32;
   localparam int unsigned POS_W      = 4;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned MAP_DEPTH  = 256;
   localparam int unsigned MAP_ADDR_W = $clog2(MAP_DEPTH);

   typedef logic [SCAN_W-1:0]     scan_type;
   typedef logic [CODE_W-1:0]     code_type;
   typedef logic [TICK_W-1:0]     tick_type;
   typedef logic [POS_W-1:0]      pos_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [MAP_ADDR_W-1:0] map_addr_type;

   // Register indexes on the configuration port.
   localparam csr_idx_type CSR_PRINT_SCREEN_KEYCODE = CSR_IDX_W'(0);
   localparam csr_idx_type CSR_PAUSE_KEYCODE        = CSR_IDX_W'(1);

   // Register reset values.
   localparam code_type PRINT_SCREEN_RESET = 8'd183;
   localparam code_type PAUSE_RESET        = 8'd197;

   // Prefix bytes.
   localparam scan_type SCAN_EXT   = 8'hE0;
   localparam scan_type SCAN_PAUSE = 8'hE1;

   // Sequence positions: 1..3 inside Print Screen, 5..9 inside Pause.
   localparam pos_type SEQ_IDLE        = POS_W'(0);
   localparam pos_type SEQ_PS_FIRST    = POS_W'(1);
   localparam pos_type SEQ_PS_LAST     = POS_W'(3);
   localparam pos_type SEQ_GAP         = POS_W'(4);
   localparam pos_type SEQ_PAUSE_FIRST = POS_W'(5);
   localparam pos_type SEQ_PAUSE_LAST  = POS_W'(9);
   localparam pos_type SEQ_END         = POS_W'(10);

   // Expected byte at each sequence position.
   function automatic scan_type seq_byte(input pos_type pos);
      scan_type b;
      unique case (pos)
         4'd0:    b = 8'hE0;
         4'd1:    b = 8'h2A;
         4'd2:    b = 8'hE0;
         4'd3:    b = 8'h37;
         4'd4:    b = 8'hE1;
         4'd5:    b = 8'h1D;
         4'd6:    b = 8'h45;
         4'd7:    b = 8'hE1;
         4'd8:    b = 8'h9D;
         4'd9:    b = 8'hC5;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// File: rtl/keyboard_scan_code_decoder.sv
// ----------------------------------------------------------------------------
// Keyboard scan code decoder
// Decodes set-1 scan bytes into key press and release events, matching the
// Print Screen and Pause sequences and suppressing typematic repeats.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  req_      in         req_valid/req_ready  req_scan_byte, req_tick_in
//  rsp_      out        rsp_valid/rsp_ready  rsp_key_code, rsp_is_release,
//                                            rsp_tick_out
//  csr_      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One scan byte can be taken every cycle unless req_ready is held low. A byte
// that yields a key candidate passes through the lookup stage, where the
// key-down map bit read at transfer time is checked, and then lands in the
// output register that drives the event. The key-down map has a single read
// and a single write port, each used at most once per byte.
// After reset all 256 map entries are swept to zero, one entry per cycle,
// while req_ready stays low; configuration writes are taken at all
// times. A stalled output holds the lookup stage, which in turn holds off
// new input transfers.
// ----------------------------------------------------------------------------
module keyboard_scan_code_decoder
   import kscd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  scan_type    req_scan_byte,
   input  tick_type    req_tick_in,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output code_type    rsp_key_code,
   output logic        rsp_is_release,
   output tick_type    rsp_tick_out,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  csr_idx_type csr_index,
   input  code_type    csr_wdata
);

   // Configuration registers.
   code_type     ps_code_ff, ps_code_in;
   code_type     pause_code_ff, pause_code_in;

   // Sequence tracking.
   logic         ext_ff, ext_in;
   pos_type      pos_ff, pos_in;

   // Clearing sweep of the key-down map after reset.
   logic         clearing_ff, clearing_in;
   map_addr_type clr_addr_ff, clr_addr_in;

   // Lookup stage.
   logic         s1_valid_ff, s1_valid_in;
   code_type     s1_code_ff;
   logic         s1_release_ff;
   tick_type     s1_tick_ff;
   logic         s1_bit_ff;

   // Output register.
   logic         rsp_valid_ff, rsp_valid_in;
   code_type     rsp_code_ff;
   logic         rsp_release_ff;
   tick_type     rsp_tick_ff;

   // Key-down map.
   logic         key_map [MAP_DEPTH];

   logic         req_fire;
   logic         s1_fire;
   logic         s1_emit;
   logic         s1_wr_data;
   logic         seq_match;
   logic         key_cand;
   code_type     cand_code;
   logic         cand_release;
   logic         map_we;
   map_addr_type map_waddr;
   logic         map_wdata;
   logic         fwd_hit;

   // ---------------------------------------------------------------------
   // Handshakes
   // ---------------------------------------------------------------------
   // The lookup stage moves on when the output register is empty or is
   // being drained in this cycle; a byte without an event simply drops out.
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clearing_ff && (!s1_valid_ff || s1_fire);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------------
   // Sequence decode at input transfer time
   // ---------------------------------------------------------------------
   assign seq_match = (pos_ff != SEQ_IDLE) && (pos_ff < SEQ_END) && (pos_ff != SEQ_GAP)
                      && (req_scan_byte == seq_byte(pos_ff));

   always_comb begin
      ext_in       = ext_ff;
      pos_in       = pos_ff;
      key_cand     = 1'b0;
      cand_code    = {ext_ff, req_scan_byte[SCAN_W-2:0]};
      cand_release = req_scan_byte[SCAN_W-1];
      if (req_fire) begin
         priority if (pos_ff == SEQ_IDLE && req_scan_byte == SCAN_EXT) begin
            // Extended prefix, which may also open Print Screen.
            ext_in = 1'b1;
            pos_in = SEQ_PS_FIRST;
         end else if (pos_ff == SEQ_IDLE && req_scan_byte == SCAN_PAUSE) begin
            pos_in = SEQ_PAUSE_FIRST;
         end else if (seq_match && pos_ff == SEQ_PS_LAST) begin
            pos_in       = SEQ_IDLE;
            ext_in       = 1'b0;
            key_cand     = 1'b1;
            cand_code    = ps_code_ff;
            cand_release = 1'b0;
         end else if (seq_match && pos_ff == SEQ_PAUSE_LAST) begin
            pos_in       = SEQ_IDLE;
            key_cand     = 1'b1;
            cand_code    = pause_code_ff;
            cand_release = 1'b0;
         end else if (seq_match) begin
            pos_in = pos_ff + POS_W'(1);
         end else begin
            // Ordinary byte, or a broken sequence decoded as an ordinary key
            // with whatever extended flag is pending.
            pos_in   = SEQ_IDLE;
            ext_in   = 1'b0;
            key_cand = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Lookup stage: decide the event and the map update
   // ---------------------------------------------------------------------
   // A release always gives an event and clears the bit. A press of a key
   // already down gives nothing; a new press sets the bit unless it is the
   // Pause key.
   assign s1_emit    = s1_release_ff || !s1_bit_ff;
   assign s1_wr_data = !s1_release_ff && (s1_bit_ff || (s1_code_ff != pause_code_ff));

   assign s1_valid_in = (req_fire && key_cand) ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_fire ? s1_emit : (rsp_valid_ff && !rsp_ready);

   // ---------------------------------------------------------------------
   // Map write port: clearing sweep or the lookup stage's write-back
   // ---------------------------------------------------------------------
   always_comb begin
      if (clearing_ff) begin
         map_we    = 1'b1;
         map_waddr = clr_addr_ff;
         map_wdata = 1'b0;
      end else begin
         map_we    = s1_fire;
         map_waddr = s1_code_ff;
         map_wdata = s1_wr_data;
      end
   end

   // A byte taken in the same cycle as a write-back to the same key would
   // read the stale bit, so the written value is passed straight across.
   assign fwd_hit = map_we && (map_waddr == cand_code);

   assign clr_addr_in = clearing_ff ? clr_addr_ff + MAP_ADDR_W'(1) : clr_addr_ff;
   assign clearing_in = clearing_ff && (clr_addr_ff != map_addr_type'(MAP_DEPTH - 1));

   // ---------------------------------------------------------------------
   // Configuration writes; indexes beyond the list are ignored.
   // ---------------------------------------------------------------------
   always_comb begin
      ps_code_in    = ps_code_ff;
      pause_code_in = pause_code_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_PRINT_SCREEN_KEYCODE) begin
            ps_code_in = csr_wdata;
         end else if (csr_index == CSR_PAUSE_KEYCODE) begin
            pause_code_in = csr_wdata;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         ps_code_ff    <= PRINT_SCREEN_RESET;
         pause_code_ff <= PAUSE_RESET;
         ext_ff        <= 1'b0;
         pos_ff        <= SEQ_IDLE;
         clearing_ff   <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         ps_code_ff    <= ps_code_in;
         pause_code_ff <= pause_code_in;
         ext_ff        <= ext_in;
         pos_ff        <= pos_in;
         clearing_ff   <= clearing_in;
         clr_addr_ff   <= clr_addr_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && key_cand) begin
         s1_code_ff    <= cand_code;
         s1_release_ff <= cand_release;
         s1_tick_ff    <= req_tick_in;
      end
      if (s1_fire) begin
         rsp_code_ff    <= s1_code_ff;
         rsp_release_ff <= s1_release_ff;
         rsp_tick_ff    <= s1_tick_ff;
      end
   end

   // Key-down map: one synchronous read and one write port.
   always_ff @(posedge clock) begin
      if (map_we) begin
         key_map[map_waddr] <= map_wdata;
      end
      if (req_fire && key_cand) begin
         s1_bit_ff <= fwd_hit ? map_wdata : key_map[cand_code];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_key_code   = rsp_code_ff;
   assign rsp_is_release = rsp_release_ff;
   assign rsp_tick_out   = rsp_tick_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_no_input_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !req_ready)
      else $error("input transfer possible during map clearing");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_fire) |=> (s1_valid_ff && $stable(s1_code_ff)
                                     && $stable(s1_bit_ff)))
      else $error("lookup stage lost or changed a stalled item");

   a_forwarding: assert property (@(posedge clock) disable iff (reset)
      (req_fire && key_cand && s1_fire && (s1_code_ff == cand_code))
      |=> (s1_bit_ff == $past(s1_wr_data)))
      else $error("map write-back not forwarded to the following lookup");

   a_pos_reachable: assert property (@(posedge clock) disable iff (reset)
      (pos_ff != SEQ_GAP) && (pos_ff < SEQ_END))
      else $error("sequence position took an unreachable value");

endmodule
